### rtl/lsrc_pkg.sv
// ----------------------------------------------------------------------------
// lsrc_pkg
// Shared widths, types and register codes of the line segment clipper.
// ----------------------------------------------------------------------------
package lsrc_pkg;

  // coordinate and fraction widths
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  // derived widths
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int T_BITS     = FRAC_BITS + 1;

  // divider widths: divisor is twice a denominator, quotient covers t and offsets
  localparam int DIV_D_BITS = COORD_BITS + 1;
  localparam int DIV_Q_BITS = (FRAC_BITS + 1 > COORD_BITS + 1) ? FRAC_BITS + 1 : COORD_BITS + 1;
  localparam int DIV_N_BITS = DIV_D_BITS + DIV_Q_BITS;

  // divider lanes
  localparam int LANES       = 6;
  localparam int LANE_T_ENTER = 0;
  localparam int LANE_T_EXIT  = 1;
  localparam int LANE_SX      = 2;
  localparam int LANE_SY      = 3;
  localparam int LANE_EX      = 4;
  localparam int LANE_EY      = 5;

  // configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int ADDR_BITS     = 4;
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_X_MAX = 2'd1;
  localparam logic [1:0] REG_Y_MIN = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic        [MAG_BITS-1:0]   mag_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic        [T_BITS-1:0]     tpar_t;
  typedef logic        [DIV_N_BITS-1:0] div_num_t;
  typedef logic        [DIV_D_BITS-1:0] div_den_t;
  typedef logic        [DIV_Q_BITS-1:0] div_quo_t;

  // register reset values
  localparam coord_t RST_X_MIN = coord_t'(20);
  localparam coord_t RST_X_MAX = coord_t'(40);
  localparam coord_t RST_Y_MIN = coord_t'(20);
  localparam coord_t RST_Y_MAX = coord_t'(40);

  // one in Q1.FRAC_BITS
  localparam tpar_t T_ONE = tpar_t'(1) << FRAC_BITS;

  // ordered clip rectangle
  typedef struct packed {
    coord_t x_lo;
    coord_t x_hi;
    coord_t y_lo;
    coord_t y_hi;
  } rect_t;

  // data that rides along the divider
  typedef struct packed {
    logic   visible;
    coord_t sx;
    coord_t sy;
  } side_t;

endpackage

### rtl/lsrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsrc_cfg_regs
// Clip rectangle registers behind the APB-style port, with min/max ordering.
// ----------------------------------------------------------------------------
module lsrc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsrc_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [lsrc_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [lsrc_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output lsrc_pkg::rect_t                     rect_o
);
  import lsrc_pkg::*;

  coord_t     x_min_q, x_max_q, y_min_q, y_max_q;
  coord_t     rd_val;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q <= RST_X_MIN;
      x_max_q <= RST_X_MAX;
      y_min_q <= RST_Y_MIN;
      y_max_q <= RST_Y_MAX;
    end else if (wr_en) begin
      unique case (idx)
        REG_X_MIN: x_min_q <= pwdata[COORD_BITS-1:0];
        REG_X_MAX: x_max_q <= pwdata[COORD_BITS-1:0];
        REG_Y_MIN: y_min_q <= pwdata[COORD_BITS-1:0];
        REG_Y_MAX: y_max_q <= pwdata[COORD_BITS-1:0];
        default:   x_min_q <= x_min_q;
      endcase
    end
  end

  // read back, sign extended
  always_comb begin
    unique case (idx)
      REG_X_MIN: rd_val = x_min_q;
      REG_X_MAX: rd_val = x_max_q;
      REG_Y_MIN: rd_val = y_min_q;
      REG_Y_MAX: rd_val = y_max_q;
      default:   rd_val = x_min_q;
    endcase
  end
  assign prdata = {{(APB_DATA_BITS-COORD_BITS){rd_val[COORD_BITS-1]}}, rd_val};

  // swapped limits are used in sorted order
  assign rect_o.x_lo = (x_min_q < x_max_q) ? x_min_q : x_max_q;
  assign rect_o.x_hi = (x_min_q < x_max_q) ? x_max_q : x_min_q;
  assign rect_o.y_lo = (y_min_q < y_max_q) ? y_min_q : y_max_q;
  assign rect_o.y_hi = (y_min_q < y_max_q) ? y_max_q : y_min_q;

endmodule

### rtl/lsrc_front.sv
// ----------------------------------------------------------------------------
// lsrc_front
// Six-stage front end: edge terms, candidates, exact entry/exit selection by
// cross multiplication, reject test and divider operands.
// ----------------------------------------------------------------------------
module lsrc_front (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  lsrc_pkg::rect_t                               rect_i,
  input  logic                                          in_valid_i,
  output logic                                          in_stall_o,
  input  lsrc_pkg::coord_t                              start_x_i,
  input  lsrc_pkg::coord_t                              start_y_i,
  input  lsrc_pkg::coord_t                              end_x_i,
  input  lsrc_pkg::coord_t                              end_y_i,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output lsrc_pkg::side_t                               side_o,
  output lsrc_pkg::div_num_t [lsrc_pkg::LANES-1:0]      num_o,
  output lsrc_pkg::div_den_t [lsrc_pkg::LANES-1:0]      den_o
);
  import lsrc_pkg::*;

  localparam int NST = 6;

  typedef logic signed [DIV_N_BITS-1:0] snum_t;

  typedef struct packed {
    diff_t d;
    mag_t  m;
    diff_t nen;
    diff_t nex;
    logic  rej;
  } axis_t;

  typedef struct packed {
    diff_t n;
    mag_t  d;
  } frac_t;

  typedef struct packed {
    frac_t en;
    frac_t ex;
  } cand_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    axis_t  ax;
    axis_t  ay;
  } s1_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    diff_t  dx;
    diff_t  dy;
    logic   rej;
    cand_t  cx;
    cand_t  cy;
  } s2_t;

  typedef struct packed {
    s2_t   b;
    prod_t pe_x;
    prod_t pe_y;
    prod_t px_x;
    prod_t px_y;
  } s3_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    diff_t  dx;
    diff_t  dy;
    logic   rej;
    frac_t  en;
    frac_t  ex;
  } s4_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    logic   rej;
    frac_t  en;
    frac_t  ex;
    prod_t  cmp_a;
    prod_t  cmp_b;
    prod_t  off_sx;
    prod_t  off_sy;
    prod_t  off_ex;
    prod_t  off_ey;
  } s5_t;

  typedef struct packed {
    side_t                    side;
    div_num_t [LANES-1:0]     num;
    div_den_t [LANES-1:0]     den;
  } s6_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;
  logic [NST-1:0] v_q;
  logic [NST-1:0] ld;

  // edge terms along one axis
  function automatic axis_t edge_terms(coord_t s, coord_t e, coord_t lo, coord_t hi);
    axis_t a;
    a.d   = diff_t'(e) - diff_t'(s);
    a.m   = mag_t'((a.d < 0) ? -a.d : a.d);
    a.nen = (a.d > 0) ? diff_t'(lo) - diff_t'(s) : diff_t'(s) - diff_t'(hi);
    a.nex = (a.d > 0) ? diff_t'(hi) - diff_t'(s) : diff_t'(s) - diff_t'(lo);
    a.rej = (a.d == 0) && ((s < lo) || (s > hi));
    return a;
  endfunction

  function automatic diff_t to_s(mag_t m);
    return {1'b0, m};
  endfunction

  // entry and exit candidates; entry clamped to at least 0, exit to at most 1
  function automatic cand_t candidates(axis_t a);
    cand_t c;
    if ((a.d != 0) && (a.nen > 0)) begin
      c.en.n = a.nen;
      c.en.d = a.m;
    end else begin
      c.en.n = diff_t'(0);
      c.en.d = mag_t'(1);
    end
    if ((a.d != 0) && (a.nex < to_s(a.m))) begin
      c.ex.n = a.nex;
      c.ex.d = a.m;
    end else begin
      c.ex.n = diff_t'(1);
      c.ex.d = mag_t'(1);
    end
    return c;
  endfunction

  function automatic prod_t mul(diff_t a, diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // 2*p + d + d*2^(COORD_BITS+1): floor of this over 2d is round(p/d) + 2^COORD_BITS
  function automatic div_num_t coord_num(prod_t p, mag_t d);
    snum_t dd;
    dd = snum_t'({1'b0, d});
    return div_num_t'((snum_t'(p) <<< 1) + dd + (dd <<< (COORD_BITS + 1)));
  endfunction

  // stage 1: edge terms
  always_comb begin
    s1_d.sx = start_x_i;
    s1_d.sy = start_y_i;
    s1_d.ax = edge_terms(start_x_i, end_x_i, rect_i.x_lo, rect_i.x_hi);
    s1_d.ay = edge_terms(start_y_i, end_y_i, rect_i.y_lo, rect_i.y_hi);
  end

  // stage 2: candidate fractions
  always_comb begin
    s2_d.sx  = s1_q.sx;
    s2_d.sy  = s1_q.sy;
    s2_d.dx  = s1_q.ax.d;
    s2_d.dy  = s1_q.ay.d;
    s2_d.rej = s1_q.ax.rej || s1_q.ay.rej;
    s2_d.cx  = candidates(s1_q.ax);
    s2_d.cy  = candidates(s1_q.ay);
  end

  // stage 3: cross products between axes
  always_comb begin
    s3_d.b    = s2_q;
    s3_d.pe_x = mul(s2_q.cx.en.n, to_s(s2_q.cy.en.d));
    s3_d.pe_y = mul(s2_q.cy.en.n, to_s(s2_q.cx.en.d));
    s3_d.px_x = mul(s2_q.cx.ex.n, to_s(s2_q.cy.ex.d));
    s3_d.px_y = mul(s2_q.cy.ex.n, to_s(s2_q.cx.ex.d));
  end

  // stage 4: largest entry, smallest exit
  always_comb begin
    s4_d.sx  = s3_q.b.sx;
    s4_d.sy  = s3_q.b.sy;
    s4_d.dx  = s3_q.b.dx;
    s4_d.dy  = s3_q.b.dy;
    s4_d.rej = s3_q.b.rej;
    s4_d.en  = (s3_q.pe_y > s3_q.pe_x) ? s3_q.b.cy.en : s3_q.b.cx.en;
    s4_d.ex  = (s3_q.px_y < s3_q.px_x) ? s3_q.b.cy.ex : s3_q.b.cx.ex;
  end

  // stage 5: ordering products and endpoint offsets
  always_comb begin
    s5_d.sx     = s4_q.sx;
    s5_d.sy     = s4_q.sy;
    s5_d.rej    = s4_q.rej;
    s5_d.en     = s4_q.en;
    s5_d.ex     = s4_q.ex;
    s5_d.cmp_a  = mul(s4_q.en.n, to_s(s4_q.ex.d));
    s5_d.cmp_b  = mul(s4_q.ex.n, to_s(s4_q.en.d));
    s5_d.off_sx = mul(s4_q.en.n, s4_q.dx);
    s5_d.off_sy = mul(s4_q.en.n, s4_q.dy);
    s5_d.off_ex = mul(s4_q.ex.n, s4_q.dx);
    s5_d.off_ey = mul(s4_q.ex.n, s4_q.dy);
  end

  // stage 6: reject test and divider operands
  always_comb begin
    s6_d.side.visible = !s5_q.rej && !(s5_q.cmp_a > s5_q.cmp_b);
    s6_d.side.sx      = s5_q.sx;
    s6_d.side.sy      = s5_q.sy;
    s6_d.num[LANE_T_ENTER] = (div_num_t'(s5_q.en.n[MAG_BITS-1:0]) << (FRAC_BITS + 1))
                             + div_num_t'(s5_q.en.d);
    s6_d.num[LANE_T_EXIT]  = (div_num_t'(s5_q.ex.n[MAG_BITS-1:0]) << (FRAC_BITS + 1))
                             + div_num_t'(s5_q.ex.d);
    s6_d.num[LANE_SX] = coord_num(s5_q.off_sx, s5_q.en.d);
    s6_d.num[LANE_SY] = coord_num(s5_q.off_sy, s5_q.en.d);
    s6_d.num[LANE_EX] = coord_num(s5_q.off_ex, s5_q.ex.d);
    s6_d.num[LANE_EY] = coord_num(s5_q.off_ey, s5_q.ex.d);
    s6_d.den[LANE_T_ENTER] = {s5_q.en.d, 1'b0};
    s6_d.den[LANE_T_EXIT]  = {s5_q.ex.d, 1'b0};
    s6_d.den[LANE_SX]      = {s5_q.en.d, 1'b0};
    s6_d.den[LANE_SY]      = {s5_q.en.d, 1'b0};
    s6_d.den[LANE_EX]      = {s5_q.ex.d, 1'b0};
    s6_d.den[LANE_EY]      = {s5_q.ex.d, 1'b0};
  end

  // stage loads: a stage takes new data when empty or when it moves on
  always_comb begin
    ld[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ld[0]) s1_q <= s1_d;
    if (ld[1]) s2_q <= s2_d;
    if (ld[2]) s3_q <= s3_d;
    if (ld[3]) s4_q <= s4_d;
    if (ld[4]) s5_q <= s5_d;
    if (ld[5]) s6_q <= s6_d;
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = v_q[NST-1];
  assign side_o      = s6_q.side;
  assign num_o       = s6_q.num;
  assign den_o       = s6_q.den;

endmodule

### rtl/lsrc_div_pipe.sv
// ----------------------------------------------------------------------------
// lsrc_div_pipe
// Pipelined restoring divider, one quotient bit per stage, six lanes wide.
// ----------------------------------------------------------------------------
module lsrc_div_pipe (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  lsrc_pkg::side_t                           side_i,
  input  lsrc_pkg::div_num_t [lsrc_pkg::LANES-1:0]  num_i,
  input  lsrc_pkg::div_den_t [lsrc_pkg::LANES-1:0]  den_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output lsrc_pkg::side_t                           side_o,
  output lsrc_pkg::div_quo_t [lsrc_pkg::LANES-1:0]  quo_o
);
  import lsrc_pkg::*;

  localparam int STAGES = DIV_Q_BITS;

  typedef struct packed {
    div_den_t rem;
    div_quo_t low;
    div_quo_t quo;
    div_den_t den;
  } lane_t;

  typedef struct packed {
    side_t                 side;
    lane_t [LANES-1:0]     lane;
  } stage_t;

  stage_t pre  [STAGES];
  stage_t nxt  [STAGES];
  stage_t st_q [STAGES];
  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] ld;

  // one compare and subtract step
  function automatic lane_t step(lane_t a);
    logic [DIV_D_BITS:0] trial;
    logic [DIV_D_BITS:0] diff;
    lane_t               r;
    trial = {a.rem, a.low[DIV_Q_BITS-1]};
    diff  = trial - {1'b0, a.den};
    r     = a;
    r.low = a.low << 1;
    if (trial >= {1'b0, a.den}) begin
      r.rem = diff[DIV_D_BITS-1:0];
      r.quo = {a.quo[DIV_Q_BITS-2:0], 1'b1};
    end else begin
      r.rem = trial[DIV_D_BITS-1:0];
      r.quo = {a.quo[DIV_Q_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  // stage inputs and step logic
  always_comb begin
    pre[0].side = side_i;
    for (int l = 0; l < LANES; l++) begin
      pre[0].lane[l].rem = num_i[l][DIV_N_BITS-1:DIV_Q_BITS];
      pre[0].lane[l].low = num_i[l][DIV_Q_BITS-1:0];
      pre[0].lane[l].quo = '0;
      pre[0].lane[l].den = den_i[l];
    end
    for (int k = 1; k < STAGES; k++) begin
      pre[k] = st_q[k-1];
    end
    for (int k = 0; k < STAGES; k++) begin
      nxt[k].side = pre[k].side;
      for (int l = 0; l < LANES; l++) begin
        nxt[k].lane[l] = step(pre[k].lane[l]);
      end
    end
  end

  // stage loads
  always_comb begin
    ld[STAGES-1] = !v_q[STAGES-1] || !out_stall_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < STAGES; k++) begin
        if (ld[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < STAGES; k++) begin
      if (ld[k]) st_q[k] <= nxt[k];
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = v_q[STAGES-1];
  assign side_o      = st_q[STAGES-1].side;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = st_q[STAGES-1].lane[l].quo;
    end
  end

endmodule

### rtl/line_segment_rect_clipper_unit.sv
// ----------------------------------------------------------------------------
// line_segment_rect_clipper_unit
// Liang-Barsky clipping of integer line segments against a rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one segment per transfer,
//   as two signed endpoints. The output channel (out_valid_o / out_stall_i)
//   returns one result per segment, in order: visible flag, entry and exit
//   parameters in Q1.16 (65536 is one) and the clipped endpoints, rounded to
//   nearest. A rejected segment returns all zero fields.
//   The clip rectangle sits in four registers on the APB-style port (byte
//   addresses 0, 4, 8, 12: x min, x max, y min, y max); swapped limits are
//   used in sorted order. Write them only while no segment is in flight.
// Timing:
//   24 register stages: six front stages, 17 divider stages (one quotient bit
//   per stage) and the output register. One segment per cycle is accepted
//   sustained while the receiver does not stall.
// Reset and stall:
//   Reset empties the pipeline and loads the rectangle 20..40 by 20..40.
//   While the receiver stalls, empty stages still fill; in_stall_o rises only
//   once every stage holds a segment.
// ----------------------------------------------------------------------------
module line_segment_rect_clipper_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsrc_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [lsrc_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [lsrc_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  // segment input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lsrc_pkg::coord_t                    start_x_i,
  input  lsrc_pkg::coord_t                    start_y_i,
  input  lsrc_pkg::coord_t                    end_x_i,
  input  lsrc_pkg::coord_t                    end_y_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                visible_o,
  output lsrc_pkg::tpar_t                     t_enter_o,
  output lsrc_pkg::tpar_t                     t_exit_o,
  output lsrc_pkg::coord_t                    clipped_start_x_o,
  output lsrc_pkg::coord_t                    clipped_start_y_o,
  output lsrc_pkg::coord_t                    clipped_end_x_o,
  output lsrc_pkg::coord_t                    clipped_end_y_o
);
  import lsrc_pkg::*;

  typedef struct packed {
    logic   visible;
    tpar_t  t_enter;
    tpar_t  t_exit;
    coord_t csx;
    coord_t csy;
    coord_t cex;
    coord_t cey;
  } out_t;

  rect_t                 rect;
  logic                  fr_valid, fr_stall;
  side_t                 fr_side;
  div_num_t [LANES-1:0]  fr_num;
  div_den_t [LANES-1:0]  fr_den;
  logic                  dv_valid, dv_stall;
  side_t                 dv_side;
  div_quo_t [LANES-1:0]  dv_quo;
  out_t                  out_d, out_q;
  logic                  out_v_q;
  logic                  out_ld;

  lsrc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rect_o  (rect)
  );

  lsrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rect_i      (rect),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (fr_valid),
    .out_stall_i (fr_stall),
    .side_o      (fr_side),
    .num_o       (fr_num),
    .den_o       (fr_den)
  );

  lsrc_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_stall_o  (fr_stall),
    .side_i      (fr_side),
    .num_i       (fr_num),
    .den_i       (fr_den),
    .out_valid_o (dv_valid),
    .out_stall_i (dv_stall),
    .side_o      (dv_side),
    .quo_o       (dv_quo)
  );

  // result formatting; offsets carry a bias of 2^COORD_BITS that wraps away
  always_comb begin
    out_d = '0;
    if (dv_side.visible) begin
      out_d.visible = 1'b1;
      out_d.t_enter = dv_quo[LANE_T_ENTER][T_BITS-1:0];
      out_d.t_exit  = dv_quo[LANE_T_EXIT][T_BITS-1:0];
      out_d.csx     = coord_t'(dv_side.sx + coord_t'(dv_quo[LANE_SX][COORD_BITS-1:0]));
      out_d.csy     = coord_t'(dv_side.sy + coord_t'(dv_quo[LANE_SY][COORD_BITS-1:0]));
      out_d.cex     = coord_t'(dv_side.sx + coord_t'(dv_quo[LANE_EX][COORD_BITS-1:0]));
      out_d.cey     = coord_t'(dv_side.sy + coord_t'(dv_quo[LANE_EY][COORD_BITS-1:0]));
    end
  end

  // output register
  assign out_ld   = !out_v_q || !out_stall_i;
  assign dv_stall = !out_ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_ld) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) out_q <= out_d;
  end

  assign out_valid_o       = out_v_q;
  assign visible_o         = out_q.visible;
  assign t_enter_o         = out_q.t_enter;
  assign t_exit_o          = out_q.t_exit;
  assign clipped_start_x_o = out_q.csx;
  assign clipped_start_y_o = out_q.csy;
  assign clipped_end_x_o   = out_q.cex;
  assign clipped_end_y_o   = out_q.cey;

  // rejected segments come out all zero
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> t_enter_o == '0 && t_exit_o == '0 &&
      clipped_start_x_o == '0 && clipped_start_y_o == '0 &&
      clipped_end_x_o == '0 && clipped_end_y_o == '0)
    else $error("rejected segment with nonzero fields");

  // visible segments have ordered parameters within one
  a_param_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && visible_o |-> t_enter_o <= t_exit_o && t_exit_o <= T_ONE)
    else $error("entry and exit parameters out of order");

  // input stalls only when the whole pipeline is backed up
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule
